// ===== design/sdma_pkg.sv =====
// ============================================================================
// sdma_pkg
// Types and constants shared by the strided DMA address sequencer modules.
// ============================================================================
package sdma_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_MOVE      = 2'd0;
  localparam logic [1:0] ST_ADDR_OOR  = 2'd1;
  localparam logic [1:0] ST_SEG_OVF   = 2'd2;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] dram_addr_reg;
    logic [12:0] mem_addr_reg;
    logic [31:0] len_reg;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] main_byte_addr;
    logic [12:0] local_byte_addr;
    logic        to_main;
    logic        last;
  } out_item_t;

  // Classified command held in the queue
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  err;
    logic        dir;
    logic [12:0] row_length;
    logic [12:0] row_skip;
    logic [8:0]  rows;
    logic [23:0] main_base;
    logic [12:0] local_base;
  } cmd_t;

endpackage

// ===== design/sdma_front.sv =====
// ============================================================================
// sdma_front
// Accepts input items, checks start requests and decodes them into commands.
// ============================================================================
module sdma_front #(
  parameter int unsigned SEGMENT_BYTES = 4096,
  parameter int unsigned MAIN_LIMIT    = 8388607
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sdma_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sdma_pkg::cmd_t    q_cmd_o
);
  import sdma_pkg::*;

  logic [13:0] seg_need;
  logic [12:0] length;

  // Stall only while the queue has no room
  assign in_stall_o = q_full_i;

  // Drop mode three at the door; everything else goes to the queue
  assign q_push_o = in_valid_i && !q_full_i && (in_item_i.mode != MODE_NONE);

  // Bytes the unrounded transfer needs from the local offset on
  assign seg_need = 14'(in_item_i.len_reg[11:0]) + 14'd1 + 14'(in_item_i.mem_addr_reg[11:0]);
  assign length   = 13'({1'b0, in_item_i.len_reg[11:0] | 12'h007}) + 13'd1;

  // Classify and decode
  always_comb begin
    q_cmd_o            = '0;
    q_cmd_o.kind       = (in_item_i.mode == MODE_TICK) ? KIND_TICK : KIND_START;
    q_cmd_o.dir        = (in_item_i.mode == MODE_WRITE);
    q_cmd_o.row_length = length;
    q_cmd_o.row_skip   = 13'(in_item_i.len_reg[31:20]) + length;
    q_cmd_o.rows       = 9'({1'b0, in_item_i.len_reg[19:12]}) + 9'd1;
    q_cmd_o.main_base  = {in_item_i.dram_addr_reg[23:3], 3'b000};
    q_cmd_o.local_base = {in_item_i.mem_addr_reg[12:3], 3'b000};
    if (in_item_i.dram_addr_reg > 24'(MAIN_LIMIT)) begin
      q_cmd_o.err = ST_ADDR_OOR;
    end else if (seg_need > 14'(SEGMENT_BYTES)) begin
      q_cmd_o.err = ST_SEG_OVF;
    end else begin
      q_cmd_o.err = ST_MOVE;
    end
  end

endmodule

// ===== design/sdma_queue.sv =====
// ============================================================================
// sdma_queue
// Short command queue that decouples the front from the back.
// ============================================================================
module sdma_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdma_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output sdma_pkg::cmd_t cmd_o
);
  import sdma_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== design/sdma_back.sv =====
// ============================================================================
// sdma_back
// Executes queued commands: holds the transfer state and emits byte moves.
// ============================================================================
module sdma_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  sdma_pkg::cmd_t    q_cmd_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sdma_pkg::out_item_t out_item_o
);
  import sdma_pkg::*;

  logic        busy_q, busy_d;
  logic        dir_q, dir_d;
  logic [23:0] main_base_q, main_base_d;
  logic [12:0] local_base_q, local_base_d;
  logic [12:0] byte_q, byte_d;
  logic [8:0]  rows_q, rows_d;
  logic [12:0] row_len_q, row_len_d;
  logic [12:0] row_skip_q, row_skip_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;

  logic        advance;
  logic        take;
  logic [23:0] main_addr;
  logic [12:0] local_addr;
  logic [12:0] byte_next;
  logic [8:0]  rows_next;

  // Move on when the output register is free or being drained
  assign advance = !out_valid_q || !out_stall_i;
  assign take    = q_valid_i && advance;
  assign q_pop_o = take;

  assign main_addr  = main_base_q + 24'(byte_q);
  assign local_addr = {local_base_q[12], local_base_q[11:0] + byte_q[11:0]};
  assign byte_next  = byte_q + 13'd1;
  assign rows_next  = rows_q - 9'd1;

  // Execute one command
  always_comb begin
    busy_d       = busy_q;
    dir_d        = dir_q;
    main_base_d  = main_base_q;
    local_base_d = local_base_q;
    byte_d       = byte_q;
    rows_d       = rows_q;
    row_len_d    = row_len_q;
    row_skip_d   = row_skip_q;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    if (advance) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      case (q_cmd_i.kind)
        KIND_START: begin
          if (!busy_q) begin
            if (q_cmd_i.err != ST_MOVE) begin
              out_valid_d        = 1'b1;
              out_item_d         = '0;
              out_item_d.status  = q_cmd_i.err;
              out_item_d.to_main = q_cmd_i.dir;
            end else begin
              busy_d       = 1'b1;
              dir_d        = q_cmd_i.dir;
              main_base_d  = q_cmd_i.main_base;
              local_base_d = q_cmd_i.local_base;
              byte_d       = '0;
              rows_d       = q_cmd_i.rows;
              row_len_d    = q_cmd_i.row_length;
              row_skip_d   = q_cmd_i.row_skip;
            end
          end
        end
        KIND_TICK: begin
          if (busy_q) begin
            out_valid_d                = 1'b1;
            out_item_d.status          = ST_MOVE;
            out_item_d.main_byte_addr  = main_addr ^ 24'd3;
            out_item_d.local_byte_addr = local_addr ^ 13'd3;
            out_item_d.to_main         = dir_q;
            out_item_d.last            = 1'b0;
            byte_d                     = byte_next;
            if (byte_next >= row_len_q) begin
              byte_d       = '0;
              main_base_d  = main_base_q + 24'(row_skip_q);
              local_base_d = {local_base_q[12], local_base_q[11:0] + row_len_q[11:0]};
              rows_d       = rows_next;
              if (rows_next == '0) begin
                out_item_d.last = 1'b1;
                busy_d          = 1'b0;
              end
            end
          end
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      dir_q        <= 1'b0;
      main_base_q  <= '0;
      local_base_q <= '0;
      byte_q       <= '0;
      rows_q       <= '0;
      row_len_q    <= '0;
      row_skip_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      dir_q        <= dir_d;
      main_base_q  <= main_base_d;
      local_base_q <= local_base_d;
      byte_q       <= byte_d;
      rows_q       <= rows_d;
      row_len_q    <= row_len_d;
      row_skip_q   <= row_skip_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_err_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status != ST_MOVE) |->
      (out_item_q.last == 1'b0 && out_item_q.main_byte_addr == '0 &&
       out_item_q.local_byte_addr == '0)) else $error("error result carries addresses");
  a_busy_drop_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !busy_d) |=> (out_valid_q && out_item_q.last))
    else $error("transfer ended without a last move");
  a_rows_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rows_q != '0) else $error("busy with no rows left");
  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> byte_q < row_len_q) else $error("byte index past row end");
`endif

endmodule

// ===== design/strided_dma_address_sequencer_unit.sv =====
// ============================================================================
// strided_dma_address_sequencer_unit
// Strided DMA address sequencer: checks start requests and turns each tick
// taken during a transfer into one byte move between main and local memory.
// ============================================================================
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
//  One item per cycle sustained while out_stall_i is low; a tick's move is
//  written into the queue when accepted, then into the output register.
//  The back end sets the rate; it retires one command a cycle unless stalled.
//  Reset clears busy, the queue and out_valid_o; no clearing pass.
//  in_stall_o rises only when the two-entry queue is full, which happens only
//  while out_stall_i holds a result in the output register.
// ============================================================================
module strided_dma_address_sequencer_unit #(
  parameter int unsigned SEGMENT_BYTES = 4096,
  parameter int unsigned MAIN_LIMIT    = 8388607
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdma_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdma_pkg::out_item_t out_item_o
);
  import sdma_pkg::*;

  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd_in;
  cmd_t q_cmd_out;

  // Classify incoming items
  sdma_front #(
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .MAIN_LIMIT    (MAIN_LIMIT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in)
  );

  // Buffer commands between front and back
  sdma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out)
  );

  // Run transfers and emit results
  sdma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
